@@ rtl/ole_pkg.sv @@
// Shared types and codes for the ordered list engine.
package ole_pkg;

  // Operation codes carried on the request channel
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DELETE    = 3'd3,
    OP_REVERSE   = 3'd4,
    OP_DUMP      = 3'd5
  } op_e;

  // Result status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_POS_BAD  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // Walk index operations
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_REV
  } idx_op_e;

  // Controller to datapath
  typedef struct packed {
    logic       latch;       // capture request payload
    logic       ins;         // insert at the op's position
    logic       del;         // remove entry at walk index
    logic       rev_load;    // mirror the whole cell row
    logic       rev_shift;   // move every cell one place toward the front
    idx_op_e    idx_op;
    logic       emit;        // load the result register
    logic       emit_entry;  // result carries a dumped entry
    logic [2:0] status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       cnt_zero;
    logic       full;
    logic       pos_beyond;
    logic       scan_end;
    logic       match;
    logic       shift_done;
    logic       dump_last;
  } sts_t;

endpackage

@@ rtl/ole_datapath.sv @@
// Datapath: entry cells, count, walk index and result register.
module ole_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ole_pkg::cmd_t       cmd_i,
  output ole_pkg::sts_t       sts_o,
  input  logic [2:0]          op_i,
  input  logic signed [31:0]  value_i,
  input  logic [4:0]          position_i,
  output logic [2:0]          status_o,
  output logic signed [31:0]  entry_value_o,
  output logic [3:0]          entry_index_o,
  output logic                last_o,
  output logic [4:0]          entry_count_o
);
  import ole_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int XW   = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

  logic [31:0]     cells_q [CAPACITY];
  logic [31:0]     cells_d [CAPACITY];
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [2:0]      op_q;
  logic [31:0]     val_q;
  logic [4:0]      pos_q;

  logic [2:0]      status_q;
  logic [31:0]     value_q;
  logic [3:0]      index_q;
  logic            last_q;
  logic [4:0]      ecount_q;

  logic [CMPW-1:0] pos_ext, cnt_ext, cntd_ext;
  logic [XW-1:0]   idx_ext;
  logic [CW-1:0]   ins_pos;
  logic [31:0]     cell_rd;

  // Operand views at common widths
  assign pos_ext  = CMPW'(pos_q);
  assign cnt_ext  = CMPW'(count_q);
  assign cntd_ext = CMPW'(count_d);
  assign idx_ext  = XW'(idx_q);
  assign cell_rd  = cells_q[idx_q[IW-1:0]];

  // Insert position per op
  always_comb begin
    case (op_q)
      OP_INS_FRONT: ins_pos = '0;
      OP_INS_BACK:  ins_pos = count_q;
      default:      ins_pos = pos_ext[CW-1:0];
    endcase
  end

  // Status toward the controller
  assign sts_o.op         = op_q;
  assign sts_o.cnt_zero   = (count_q == '0);
  assign sts_o.full       = (count_q == CAP_W);
  assign sts_o.pos_beyond = (op_q == OP_INS_POS) && (pos_ext > cnt_ext);
  assign sts_o.scan_end   = (idx_q == count_q);
  assign sts_o.match      = (cell_rd == val_q);
  assign sts_o.shift_done = (idx_q == '0);
  assign sts_o.dump_last  = ((idx_q + CW'(1)) == count_q);

  // Cell row: parallel shifts with neighbor wiring, and a full mirror for the reverse load
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_d[i] = cells_q[i];
      if (cmd_i.ins) begin
        if (CW'(i) == ins_pos) begin
          cells_d[i] = val_q;
        end else if ((i > 0) && (CW'(i) > ins_pos)) begin
          cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.del) begin
        if ((i < CAPACITY - 1) && (CW'(i) >= idx_q)) begin
          cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end else if (cmd_i.rev_load) begin
        cells_d[i] = cells_q[CAPACITY - 1 - i];
      end else if (cmd_i.rev_shift) begin
        if (i < CAPACITY - 1) begin
          cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Count
  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.del) begin
      count_d = count_q - CW'(1);
    end
  end

  // Walk index (scan, dump, reverse shift count)
  always_comb begin
    case (cmd_i.idx_op)
      IDX_CLR: idx_d = '0;
      IDX_INC: idx_d = idx_q + CW'(1);
      IDX_DEC: idx_d = idx_q - CW'(1);
      IDX_REV: idx_d = CAP_W - count_q;
      default: idx_d = idx_q;
    endcase
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (cmd_i.latch) begin
      op_q  <= op_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      value_q  <= cmd_i.emit_entry ? cell_rd : '0;
      index_q  <= cmd_i.emit_entry ? idx_ext[3:0] : '0;
      last_q   <= cmd_i.emit_entry ? sts_o.dump_last : 1'b1;
      ecount_q <= cntd_ext[4:0];
    end
  end

  assign status_o      = status_q;
  assign entry_value_o = value_q;
  assign entry_index_o = index_q;
  assign last_o        = last_q;
  assign entry_count_o = ecount_q;

endmodule

@@ rtl/ole_ctrl.sv @@
// Controller: sequences one request at a time and owns the result valid.
module ole_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  ole_pkg::sts_t sts_i,
  output ole_pkg::cmd_t cmd_o
);
  import ole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REV,
    S_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.idx_op = IDX_HOLD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (out_free) begin
              cmd_o.emit = 1'b1;
              if (sts_i.pos_beyond) begin
                cmd_o.status = ST_POS_BAD;
              end else if (sts_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.status = ST_DONE;
                cmd_o.ins    = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          OP_DELETE: begin
            cmd_o.idx_op = IDX_CLR;
            state_d      = S_SCAN;
          end
          OP_REVERSE: begin
            cmd_o.rev_load = 1'b1;
            cmd_o.idx_op   = IDX_REV;
            state_d        = S_REV;
          end
          OP_DUMP: begin
            if (sts_i.cnt_zero) begin
              if (out_free) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = ST_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              cmd_o.idx_op = IDX_CLR;
              state_d      = S_DUMP;
            end
          end
          default: state_d = S_IDLE;  // unused codes: no result
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          if (out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NOTFOUND;
            state_d      = S_IDLE;
          end
        end else if (sts_i.match) begin
          if (out_free) begin
            cmd_o.del    = 1'b1;
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_DONE;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_REV: begin
        if (sts_i.shift_done) begin
          if (out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_DONE;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.rev_shift = 1'b1;
          cmd_o.idx_op    = IDX_DEC;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_entry = 1'b1;
          cmd_o.status     = ST_DONE;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = IDX_INC;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/ordered_list_engine.sv @@
// Ordered list engine top level: bounded list of signed 32-bit entries.
// Insert: the execute state loads the result. Delete: the scan walks from the front up to the match.
// Delete of an absent value: the scan walks the whole list. Reverse: mirror the row, then shift it toward the front.
// Dump: one entry per cycle while the receiver does not stall, through one read port.
// One request is in flight at a time; the next is accepted once the result is loaded.
// Reset (rst_ni low, asynchronous) empties the list; cell contents stay undefined.
module ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] entry_value_o,
  output logic [3:0]         entry_index_o,
  output logic               last_o,
  output logic [4:0]         entry_count_o
);
  import ole_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ole_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .entry_index_o (entry_index_o),
    .last_o        (last_o),
    .entry_count_o (entry_count_o)
  );

`ifndef SYNTHESIS
  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  // Inserts only into a list with room and at a valid position
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |-> (!sts.full && !sts.pos_beyond))
    else $error("insert into full list or bad position");

  // Delete only on a real match inside the list
  a_del_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del |-> (sts.match && !sts.scan_end))
    else $error("delete without match");

  // No new request while a request is still being worked
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while busy");
`endif

endmodule

@@ tb/ordered_list_engine_chk.sv @@
// Channel monitor, list predictor and result comparison for the ordered list engine.
module ordered_list_engine_chk #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]         position_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] entry_value_i,
  input  logic [3:0]         entry_index_i,
  input  logic               last_i,
  input  logic [4:0]         entry_count_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import ole_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic [3:0]         entry_index;
    logic               last;
    logic [4:0]         entry_count;
  } list_result_t;

  // Predicted list contents, front first
  logic signed [31:0] list_q [$];
  list_result_t       result_q [$];
  int                 errors;

  assign fail_count_o = errors;

  function automatic list_result_t edit_result(logic [2:0] st);
    list_result_t r;
    r.status      = st;
    r.entry_value = '0;
    r.entry_index = '0;
    r.last        = 1'b1;
    r.entry_count = 5'(list_q.size());
    return r;
  endfunction

  // Insert with the position check ahead of the full check
  function automatic logic [2:0] list_insert(int pos, logic signed [31:0] val);
    if (pos > list_q.size()) return ST_POS_BAD;
    if (list_q.size() >= CAPACITY) return ST_FULL;
    list_q.insert(pos, val);
    return ST_DONE;
  endfunction

  function automatic void apply_request(logic [2:0] op, logic signed [31:0] val,
                                        logic [4:0] pos);
    logic [2:0]         st;
    list_result_t       r;
    logic signed [31:0] rev [$];
    bit                 found;
    st = ST_DONE;
    found = 0;
    case (op)
      OP_INS_FRONT: st = list_insert(0, val);
      OP_INS_BACK:  st = list_insert(list_q.size(), val);
      OP_INS_POS:   st = list_insert(int'(pos), val);
      OP_DELETE: begin
        st = ST_NOTFOUND;
        for (int i = 0; i < list_q.size() && !found; i++) begin
          if (list_q[i] == val) begin
            list_q.delete(i);
            st = ST_DONE;
            found = 1;
          end
        end
      end
      OP_REVERSE: begin
        foreach (list_q[i]) rev.push_front(list_q[i]);
        list_q = rev;
      end
      OP_DUMP: begin
        if (list_q.size() == 0) begin
          st = ST_EMPTY;
        end else begin
          foreach (list_q[i]) begin
            r.status      = ST_DONE;
            r.entry_value = list_q[i];
            r.entry_index = 4'(i);
            r.last        = (i == list_q.size() - 1);
            r.entry_count = 5'(list_q.size());
            result_q.push_back(r);
          end
          return;
        end
      end
      default: return;  // unused codes: no result
    endcase
    result_q.push_back(edit_result(st));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r;
    list_result_t got_r;
    if (!rst_ni) begin
      list_q.delete();
      result_q.delete();
      errors <= 0;
    end else begin
      // Compare the result first: a request accepted now answers later
      if (out_valid_i && !out_stall_i) begin
        got_r = '{status_i, entry_value_i, entry_index_i, last_i, entry_count_i};
        if (result_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", got_r);
          errors <= errors + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got_r !== exp_r) begin
            if (errors < 10) $display("mismatch: expected %p actual %p", exp_r, got_r);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_request(op_i, value_i, position_i);
    end
    pending_o <= result_q.size();
  end

endmodule

@@ tb/ordered_list_engine_tb.sv @@
// Top of the ordered list engine testbench: clock, reset, requests and verdict.
module ordered_list_engine_tb;
  import ole_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 16;
  localparam int WATCHDOG = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         op_i = '0;
  logic signed [31:0] value_i = '0;
  logic [4:0]         position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic signed [31:0] entry_value_o;
  logic [3:0]         entry_index_o;
  logic               last_o;
  logic [4:0]         entry_count_o;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 9;
  int                 recv_idle_pct = 64;
  int                 quiet_cycles = 0;
  int                 list_size = 0;
  logic signed [31:0] held [$];

  always #2 clk_i = ~clk_i;

  ordered_list_engine #(.CAPACITY(CAPACITY)) dut (.*);

  ordered_list_engine_chk #(.CAPACITY(CAPACITY)) u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .value_i,
    .position_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .entry_value_i(entry_value_o), .entry_index_i(entry_index_o), .last_i(last_o),
    .entry_count_i(entry_count_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Send one request and hold it until accepted; valid drops at the next idle or at the end
  task automatic send(logic [2:0] op, logic signed [31:0] val, logic [4:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (op)
      OP_INS_FRONT, OP_INS_BACK: if (list_size < CAPACITY) begin
        list_size++;
        held.push_back(val);
      end
      OP_INS_POS: if (pos <= list_size && list_size < CAPACITY) begin
        list_size++;
        held.push_back(val);
      end
      OP_DELETE: foreach (held[i]) if (held[i] == val) begin
        list_size--;
        held.delete(i);
        break;
      end
      default: ;
    endcase
  endtask

  task automatic random_request();
    int                 pick;
    logic signed [31:0] val;
    pick = $urandom_range(99);
    // Small value pool to get matches and duplicates; wide values sometimes
    val  = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(7)) - 4;
    if (pick < 3) begin
      send(3'($urandom_range(6, 7)), val, 5'($urandom()));
    end else if (pick < 25) begin
      send(OP_INS_FRONT, val, 5'($urandom()));
    end else if (pick < 45) begin
      send(OP_INS_BACK, val, 5'($urandom()));
    end else if (pick < 65) begin
      send(OP_INS_POS, val, ($urandom_range(3) == 0) ? 5'($urandom())
                                                     : 5'($urandom_range(list_size)));
    end else if (pick < 82) begin
      if (held.size() > 0 && $urandom_range(3) != 0)
        val = held[$urandom_range(held.size() - 1)];
      send(OP_DELETE, val, 5'($urandom()));
    end else if (pick < 90) begin
      send(OP_REVERSE, val, 5'($urandom()));
    end else begin
      send(OP_DUMP, val, 5'($urandom()));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, extremes, unused codes, full list, bad positions
    send(OP_DUMP, 0, 0);
    send(OP_DELETE, 5, 0);
    send(OP_REVERSE, 0, 0);
    send(OP_INS_POS, 1, 5'd31);
    send(OP_INS_FRONT, 32'sh7fffffff, 0);
    send(OP_REVERSE, 0, 0);
    send(OP_INS_BACK, 32'sh80000000, 0);
    send(OP_INS_POS, -1, 5'd2);
    send(OP_INS_POS, 0, 5'd0);
    send(OP_INS_FRONT, 32'sh55555555, 0);
    send(OP_INS_BACK, 32'shaaaaaaaa, 0);
    send(OP_INS_POS, 3, 5'd3);
    send(OP_INS_POS, 4, 5'd16);
    send(3'd6, 0, 0);
    send(3'd7, -1, 5'd31);
    send(OP_REVERSE, 0, 0);
    send(OP_DUMP, 0, 0);
    for (int i = 0; i < 10; i++) send(OP_INS_BACK, 7, 0);
    send(OP_INS_FRONT, 9, 0);
    send(OP_INS_POS, 9, 5'd16);
    send(OP_INS_POS, 9, 5'd17);
    send(OP_DUMP, 0, 0);
    send(OP_DELETE, 7, 0);
    send(OP_DELETE, 32'sh80000000, 0);

    // Random phases with three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 9 : 0;
      for (int i = 0; i < 62; i++) random_request();
    end
    send(OP_DUMP, 0, 0);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (4 * CAPACITY) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ole_pkg.sv
rtl/ole_datapath.sv
rtl/ole_ctrl.sv
rtl/ordered_list_engine.sv
tb/ordered_list_engine_chk.sv
tb/ordered_list_engine_tb.sv
